// File: hw/rtl/particle_integrate_with_walls_defines.svh
`ifndef PARTICLE_INTEGRATE_WITH_WALLS_DEFINES_SVH
`define PARTICLE_INTEGRATE_WITH_WALLS_DEFINES_SVH

// sampled on the rising edge, skipped while reset is asserted
`define PIW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("piw check failed");

// sampled on the rising edge, also across reset
`define PIW_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("piw check failed");

`endif

// File: hw/rtl/piw_pkg.sv
package piw_pkg;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int MARGIN_LSB_DEF     = 7;

    localparam int DIV_QUOT_BITS      = 32;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = DIV_QUOT_BITS / DIV_BITS_PER_STAGE;
    localparam int FRONT_STAGES       = 2;
    localparam int BACK_STAGES        = 5;
    localparam int PIPE_STAGES        = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [16:0]        TIME_STEP_RST    = 17'd197;
    localparam logic signed [31:0] GRAVITY_X_RST    = 32'sd0;
    localparam logic signed [31:0] GRAVITY_Y_RST    = -32'sd642253;
    localparam logic signed [31:0] GRAVITY_Z_RST    = 32'sd0;
    localparam logic [30:0]        WORLD_RST        = 31'd41943;
    localparam logic signed [17:0] WALL_DAMPING_RST = -18'sd32768;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        CFG_TIME_STEP    = 3'd0,
        CFG_GRAVITY_X    = 3'd1,
        CFG_GRAVITY_Y    = 3'd2,
        CFG_GRAVITY_Z    = 3'd3,
        CFG_WORLD_X      = 3'd4,
        CFG_WORLD_Y      = 3'd5,
        CFG_WORLD_Z      = 3'd6,
        CFG_WALL_DAMPING = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef logic signed [49:0] t_prod;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [30:0]        density;
        logic signed [31:0] prev_avg_velocity;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_avg_velocity;
        logic               wall_hit;
    } t_out;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] work;
        logic [30:0] dens;
    } t_div_data;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] prev_avg_velocity;
        logic [30:0]        world;
        logic signed [31:0] gdt;
        logic               neg;
        logic               zero;
        logic               ovf;
    } t_div_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if ((x[63:31] == '0) || (x[63:31] == '1)) begin
            return x[31:0];
        end
        return x[63] ? S32_MIN : S32_MAX;
    endfunction

    // floor shift of a fixed point product, then clip to 32 bits
    function automatic logic signed [31:0] fmul_shift(input t_prod p, input int frac);
        t_prod s;
        s = p >>> frac;
        return sat32(64'(s));
    endfunction

endpackage

// File: hw/rtl/piw_div.sv
module piw_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [piw_pkg::DIV_STAGES-1:0]     i_en,
    input  piw_pkg::t_div_data                 i_data,
    input  piw_pkg::t_div_side                 i_side,
    output logic [piw_pkg::DIV_STAGES-1:0]     o_valid,
    output logic [piw_pkg::DIV_QUOT_BITS-1:0]  o_quot,
    output piw_pkg::t_div_side                 o_side
);
    import piw_pkg::*;

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] w_src_v;
    t_div_data             r_d     [DIV_STAGES];
    t_div_side             r_s     [DIV_STAGES];
    t_div_data             w_src_d [DIV_STAGES];
    t_div_side             w_src_s [DIV_STAGES];
    t_div_data             n_d     [DIV_STAGES];

    always_comb begin
        w_src_v    = {r_v[DIV_STAGES-2:0], i_valid};
        w_src_d[0] = i_data;
        w_src_s[0] = i_side;
        for (int k = 1; k < DIV_STAGES; k++) begin
            w_src_d[k] = r_d[k-1];
            w_src_s[k] = r_s[k-1];
        end
    end

    // restoring division, a few quotient bits per stage
    always_comb begin
        t_div_data   d;
        logic [31:0] sh;
        for (int k = 0; k < DIV_STAGES; k++) begin
            d = w_src_d[k];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                sh     = {d.rem[30:0], d.work[31]};
                d.work = {d.work[30:0], 1'b0};
                if (sh >= {1'b0, d.dens}) begin
                    d.rem     = sh - {1'b0, d.dens};
                    d.work[0] = 1'b1;
                end else begin
                    d.rem = sh;
                end
            end
            n_d[k] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (i_en[k]) begin
                    r_v[k] <= w_src_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (i_en[k]) begin
                r_d[k] <= n_d[k];
                r_s[k] <= w_src_s[k];
            end
        end
    end

    assign o_valid = r_v;
    assign o_quot  = r_d[DIV_STAGES-1].work;
    assign o_side  = r_s[DIV_STAGES-1];

endmodule

// File: hw/rtl/piw_back.sv
module piw_back #(
    parameter int FRAC_BITS  = piw_pkg::FRAC_BITS_DEF,
    parameter int MARGIN_LSB = piw_pkg::MARGIN_LSB_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [piw_pkg::BACK_STAGES-1:0]    i_en,
    input  logic [piw_pkg::DIV_QUOT_BITS-1:0]  i_quot,
    input  piw_pkg::t_div_side                 i_side,
    input  logic [16:0]                        i_time_step,
    input  logic signed [17:0]                 i_wall_damping,
    output logic [piw_pkg::BACK_STAGES-1:0]    o_valid,
    output piw_pkg::t_out                      o_data
);
    import piw_pkg::*;

    localparam logic signed [32:0] MARGIN_W   = 33'(MARGIN_LSB);
    localparam logic signed [31:0] MARGIN_POS = 32'(MARGIN_LSB);

    logic [BACK_STAGES-1:0] r_v;
    logic [BACK_STAGES-1:0] w_src_v;

    // stage a: signed quotient, new velocity
    logic signed [31:0] w_quot;
    logic signed [31:0] n_a_vel;
    logic signed [31:0] r_a_vel;
    logic signed [31:0] r_a_pos;
    logic signed [31:0] r_a_avg;
    logic [30:0]        r_a_world;

    always_comb begin
        if (i_side.ovf) begin
            w_quot = i_side.zero ? '0 : (i_side.neg ? S32_MIN : S32_MAX);
        end else if (i_side.neg) begin
            w_quot = (i_quot > 32'h8000_0000) ? S32_MIN : -$signed(i_quot);
        end else begin
            w_quot = i_quot[31] ? S32_MAX : $signed(i_quot);
        end
        n_a_vel = sat32(64'(i_side.velocity) + 64'(w_quot) + 64'(i_side.gdt));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_vel   <= n_a_vel;
            r_a_pos   <= i_side.position;
            r_a_avg   <= i_side.prev_avg_velocity;
            r_a_world <= i_side.world;
        end
    end

    // stage b: position step product and first damping product
    t_prod              r_b_pv;
    t_prod              r_b_m1;
    logic signed [31:0] r_b_vel;
    logic signed [31:0] r_b_pos;
    logic signed [31:0] r_b_avg;
    logic [30:0]        r_b_world;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_pv    <= r_a_vel * $signed({1'b0, i_time_step});
            r_b_m1    <= r_a_vel * i_wall_damping;
            r_b_vel   <= r_a_vel;
            r_b_pos   <= r_a_pos;
            r_b_avg   <= r_a_avg;
            r_b_world <= r_a_world;
        end
    end

    // stage c: position update and wall clamps
    logic signed [31:0] w_pv;
    logic signed [31:0] w_pos1;
    logic signed [32:0] w_hi;
    logic               w_hit_hi;
    logic signed [31:0] w_pos2;
    logic               w_low;
    logic signed [31:0] n_c_pos;
    logic signed [31:0] n_c_d1;
    logic signed [31:0] r_c_pos;
    logic               r_c_hit;
    logic               r_c_damp1;
    logic               r_c_damp2;
    logic signed [31:0] r_c_vel;
    logic signed [31:0] r_c_d1;
    logic signed [31:0] r_c_avg;

    always_comb begin
        w_pv     = fmul_shift(r_b_pv, FRAC_BITS);
        w_pos1   = sat32(64'(r_b_pos) + 64'(w_pv));
        w_hi     = $signed({2'b00, r_b_world}) - MARGIN_W;
        w_hit_hi = (w_pos1 >= w_hi);
        w_pos2   = w_hit_hi ? w_hi[31:0] : w_pos1;
        // upper wall below zero also trips the lower clamp
        w_low    = w_pos2[31];
        n_c_pos  = w_low ? MARGIN_POS : w_pos2;
        n_c_d1   = fmul_shift(r_b_m1, FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_pos   <= n_c_pos;
            r_c_hit   <= w_hit_hi | w_low;
            r_c_damp1 <= w_hit_hi | w_low;
            r_c_damp2 <= w_hit_hi & w_low;
            r_c_vel   <= r_b_vel;
            r_c_d1    <= n_c_d1;
            r_c_avg   <= r_b_avg;
        end
    end

    // stage d: second damping product
    t_prod              r_d_m2;
    logic signed [31:0] r_d_pos;
    logic               r_d_hit;
    logic               r_d_damp1;
    logic               r_d_damp2;
    logic signed [31:0] r_d_vel;
    logic signed [31:0] r_d_d1;
    logic signed [31:0] r_d_avg;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_d_m2    <= r_c_d1 * i_wall_damping;
            r_d_pos   <= r_c_pos;
            r_d_hit   <= r_c_hit;
            r_d_damp1 <= r_c_damp1;
            r_d_damp2 <= r_c_damp2;
            r_d_vel   <= r_c_vel;
            r_d_d1    <= r_c_d1;
            r_d_avg   <= r_c_avg;
        end
    end

    // stage e: pick velocity, average, output register
    logic signed [31:0] w_d2;
    logic signed [31:0] w_vel;
    logic signed [32:0] w_avg_sum;
    t_out               n_e;
    t_out               r_e;

    always_comb begin
        w_d2 = fmul_shift(r_d_m2, FRAC_BITS);
        if (r_d_damp2) begin
            w_vel = w_d2;
        end else if (r_d_damp1) begin
            w_vel = r_d_d1;
        end else begin
            w_vel = r_d_vel;
        end
        w_avg_sum            = 33'(r_d_avg) + 33'(w_vel);
        n_e.new_position     = r_d_pos;
        n_e.new_velocity     = w_vel;
        n_e.new_avg_velocity = w_avg_sum[32:1];
        n_e.wall_hit         = r_d_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_e <= n_e;
        end
    end

    assign w_src_v = {r_v[BACK_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < BACK_STAGES; k++) begin
                if (i_en[k]) begin
                    r_v[k] <= w_src_v[k];
                end
            end
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_e;

endmodule

// File: hw/rtl/particle_integrate_with_walls.sv
// throughput: one request per cycle while the sink takes results or a stage is empty;
// 2 front stages, 8 divider stages (4 quotient bits each), 5 back stages,
// every stage advances whenever a bubble lies ahead of it
// reset: synchronous active low, clears all valid bits and loads register defaults,
// payload registers are not reset
module particle_integrate_with_walls #(
    parameter int FRAC_BITS  = piw_pkg::FRAC_BITS_DEF,
    parameter int MARGIN_LSB = piw_pkg::MARGIN_LSB_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  piw_pkg::t_in                          i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output piw_pkg::t_out                         o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [$bits(piw_pkg::t_cfg_idx)-1:0]  i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);
    import piw_pkg::*;

    // configuration registers
    logic [16:0]        r_time_step;
    logic signed [31:0] r_gravity_x;
    logic signed [31:0] r_gravity_y;
    logic signed [31:0] r_gravity_z;
    logic [30:0]        r_world_x;
    logic [30:0]        r_world_y;
    logic [30:0]        r_world_z;
    logic signed [17:0] r_wall_damping;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= TIME_STEP_RST;
            r_gravity_x    <= GRAVITY_X_RST;
            r_gravity_y    <= GRAVITY_Y_RST;
            r_gravity_z    <= GRAVITY_Z_RST;
            r_world_x      <= WORLD_RST;
            r_world_y      <= WORLD_RST;
            r_world_z      <= WORLD_RST;
            r_wall_damping <= WALL_DAMPING_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP:    r_time_step    <= i_cfg_data[16:0];
                CFG_GRAVITY_X:    r_gravity_x    <= i_cfg_data;
                CFG_GRAVITY_Y:    r_gravity_y    <= i_cfg_data;
                CFG_GRAVITY_Z:    r_gravity_z    <= i_cfg_data;
                CFG_WORLD_X:      r_world_x      <= i_cfg_data[30:0];
                CFG_WORLD_Y:      r_world_y      <= i_cfg_data[30:0];
                CFG_WORLD_Z:      r_world_z      <= i_cfg_data[30:0];
                CFG_WALL_DAMPING: r_wall_damping <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic                    r_p_v;
    logic                    r_q_v;
    logic [PIPE_STAGES-1:0]  w_v;
    logic [PIPE_STAGES-1:0]  w_en;
    logic [DIV_STAGES-1:0]   w_div_v;
    logic [BACK_STAGES-1:0]  w_back_v;

    assign w_v = {w_back_v, w_div_v, r_q_v, r_p_v};

    // a stage may load when any stage at or after it is empty, or the output drains
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            w_en[k] = i_out_ready || ((~w_v >> k) != '0);
        end
    end

    assign o_in_ready = w_en[0];

    // stage p: per-axis selection and the two time step products
    logic signed [31:0] w_grav;
    logic [30:0]        w_world;
    t_prod              r_p_acc_dt;
    t_prod              r_p_g_dt;
    logic signed [31:0] r_p_pos;
    logic signed [31:0] r_p_vel;
    logic signed [31:0] r_p_avg;
    logic [30:0]        r_p_world;
    logic [30:0]        r_p_dens;

    always_comb begin
        case (i_in_data.axis)
            AXIS_X: begin
                w_grav  = r_gravity_x;
                w_world = r_world_x;
            end
            AXIS_Y: begin
                w_grav  = r_gravity_y;
                w_world = r_world_y;
            end
            default: begin
                w_grav  = r_gravity_z;
                w_world = r_world_z;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p_acc_dt <= i_in_data.acceleration * $signed({1'b0, r_time_step});
            r_p_g_dt   <= w_grav * $signed({1'b0, r_time_step});
            r_p_pos    <= i_in_data.position;
            r_p_vel    <= i_in_data.velocity;
            r_p_avg    <= i_in_data.prev_avg_velocity;
            r_p_world  <= w_world;
            r_p_dens   <= i_in_data.density;
        end
    end

    // stage q: magnitude, overflow test for the quotient, gravity term
    t_prod     w_mag;
    t_div_data n_q_div;
    t_div_side n_q_side;
    t_div_data r_q_div;
    t_div_side r_q_side;

    always_comb begin
        w_mag = r_p_acc_dt[49] ? -r_p_acc_dt : r_p_acc_dt;
        n_q_div.rem  = {16'd0, w_mag[47:32]};
        n_q_div.work = w_mag[31:0];
        n_q_div.dens = r_p_dens;
        n_q_side.position          = r_p_pos;
        n_q_side.velocity          = r_p_vel;
        n_q_side.prev_avg_velocity = r_p_avg;
        n_q_side.world             = r_p_world;
        n_q_side.gdt               = fmul_shift(r_p_g_dt, FRAC_BITS);
        n_q_side.neg               = r_p_acc_dt[49];
        n_q_side.zero              = (r_p_acc_dt == '0);
        // quotient of 2^32 or more, zero density included
        n_q_side.ovf               = ({15'd0, w_mag[47:32]} >= r_p_dens);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_q_div  <= n_q_div;
            r_q_side <= n_q_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_p_v <= i_in_valid;
            end
            if (w_en[1]) begin
                r_q_v <= r_p_v;
            end
        end
    end

    logic [DIV_QUOT_BITS-1:0] w_quot;
    t_div_side                w_div_side;

    piw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q_v),
        .i_en    (w_en[FRONT_STAGES +: DIV_STAGES]),
        .i_data  (r_q_div),
        .i_side  (r_q_side),
        .o_valid (w_div_v),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    piw_back #(
        .FRAC_BITS  (FRAC_BITS),
        .MARGIN_LSB (MARGIN_LSB)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_div_v[DIV_STAGES-1]),
        .i_en           (w_en[FRONT_STAGES + DIV_STAGES +: BACK_STAGES]),
        .i_quot         (w_quot),
        .i_side         (w_div_side),
        .i_time_step    (r_time_step),
        .i_wall_damping (r_wall_damping),
        .o_valid        (w_back_v),
        .o_data         (o_out_data)
    );

    assign o_out_valid = w_back_v[BACK_STAGES-1];

endmodule

// File: hw/rtl/piw_chk.sv
`include "particle_integrate_with_walls_defines.svh"

module piw_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input piw_pkg::t_out i_out_data
);
    import piw_pkg::*;

    // a result held back by the sink stays put
    `PIW_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))

    // the output register never blocks intake while it is empty
    `PIW_ASSERT(a_in_ready_when_drained, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

    // clamped or not, a delivered position is never negative
    `PIW_ASSERT(a_pos_nonneg, i_clk, i_rst_n, i_out_valid |-> !i_out_data.new_position[31])

    `PIW_ASSERT_NORST(a_reset_flush, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind particle_integrate_with_walls piw_chk u_piw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
